### rtl/hamming_nearest_descriptor_match_assert.svh
// Assertion macros for the Hamming descriptor matcher.
// Expect clk_i and rst_ni in the scope of every use.
`ifndef HAMMING_NEAREST_DESCRIPTOR_MATCH_ASSERT_SVH
`define HAMMING_NEAREST_DESCRIPTOR_MATCH_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define HNDM_ASSERT_IMPL(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error(msg);
// Next-cycle implication.
`define HNDM_ASSERT_NEXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error(msg);
`else
`define HNDM_ASSERT_IMPL(lbl, a, b, msg)
`define HNDM_ASSERT_NEXT(lbl, a, b, msg)
`endif
`endif

### rtl/hndm_pkg.sv
// Shared constants, types and popcount helpers of the descriptor matcher.
// No dependencies.
`default_nettype none
package hndm_pkg;

  localparam int REF_DEPTH  = 1024;
  localparam int DESC_BYTES = 32;
  localparam int DEF_THRESH = 45;
  localparam int BYTE_BITS  = 8;

  localparam int WORDS      = 4;
  localparam int WORD_BITS  = 64;
  localparam int DESC_W     = WORDS * WORD_BITS;
  localparam int DESC_BITS  = DESC_BYTES * BYTE_BITS;

  localparam int LANES      = 4;
  localparam int LANE_W     = $clog2(LANES);
  localparam int ROWS       = REF_DEPTH / LANES;
  localparam int ROW_W      = $clog2(ROWS);
  localparam int IDX_W      = ROW_W + LANE_W;
  localparam int COUNT_W    = $clog2(REF_DEPTH + 1);
  localparam int DIST_W     = $clog2(DESC_BITS + 1);
  localparam int PART_W     = $clog2(WORD_BITS + 1);
  localparam int THR_W      = 9;
  localparam int QIDX_W     = 16;
  localparam int OIDX_W     = 10;
  localparam int LANE_LAT   = 3;

  localparam logic [DESC_W-1:0] DESC_MASK = {DESC_W{1'b1}} >> (DESC_W - DESC_BITS);

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_LOAD  = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  typedef struct packed {
    logic                           active;
    logic                           last;
    logic [ROW_W-1:0]               row;
    logic [LANES-1:0]               vld;
    logic [LANES-1:0][DIST_W-1:0]   distance;
  } lane_res_t;

  typedef struct packed {
    logic              done;
    logic              found;
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } merge_res_t;

  function automatic logic [3:0] pop_byte(input logic [BYTE_BITS-1:0] v);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < BYTE_BITS; i++) begin
      n = n + 4'(v[i]);
    end
    return n;
  endfunction

  function automatic logic [PART_W-1:0] pop_word(input logic [WORD_BITS-1:0] v);
    logic [PART_W-1:0] n;
    n = '0;
    for (int b = 0; b < WORD_BITS / BYTE_BITS; b++) begin
      n = n + PART_W'(pop_byte(v[b*BYTE_BITS +: BYTE_BITS]));
    end
    return n;
  endfunction

endpackage
`default_nettype wire

### rtl/hndm_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none
module hndm_ram #(
  parameter int WIDTH = 256,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

### rtl/hndm_lane.sv
// One matcher lane: a reference bank plus XOR/popcount distance pipeline.
// Depends on hndm_pkg and hndm_ram.
`default_nettype none
module hndm_lane (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        we_i,
  input  wire logic [hndm_pkg::ROW_W-1:0]  addr_i,
  input  wire logic [hndm_pkg::DESC_W-1:0] wdata_i,
  input  wire logic                        rd_en_i,
  input  wire logic [hndm_pkg::DESC_W-1:0] qdesc_i,
  output logic                             vld_o,
  output logic      [hndm_pkg::DIST_W-1:0] dist_o
);
  import hndm_pkg::*;

  logic [DESC_W-1:0]             rdata;
  logic                          vld1_q, vld2_q, vld3_q;
  logic [WORDS-1:0][PART_W-1:0]  part_d, part_q;
  logic [DIST_W-1:0]             dist_d, dist_q;
  logic [DESC_W-1:0]             diff;

  hndm_ram #(
    .WIDTH (DESC_W),
    .DEPTH (ROWS)
  ) u_bank (
    .clk_i   (clk_i),
    .we_i    (we_i),
    .addr_i  (addr_i),
    .wdata_i (wdata_i),
    .rdata_o (rdata)
  );

  // Mask off bytes beyond the descriptor length.
  assign diff = (rdata ^ qdesc_i) & DESC_MASK;

  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      part_d[w] = pop_word(diff[w*WORD_BITS +: WORD_BITS]);
    end
  end

  always_comb begin
    dist_d = '0;
    for (int w = 0; w < WORDS; w++) begin
      dist_d = dist_d + DIST_W'(part_q[w]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= rd_en_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    dist_q <= dist_d;
  end

  assign vld_o  = vld3_q;
  assign dist_o = dist_q;

endmodule
`default_nettype wire

### rtl/hndm_merge.sv
// Merge stage: picks the nearest lane of a row and folds it into the running best.
// Depends on hndm_pkg.
`default_nettype none
module hndm_merge (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clear_i,
  input  wire hndm_pkg::lane_res_t   in_i,
  output hndm_pkg::merge_res_t       res_o
);
  import hndm_pkg::*;

  logic              row_found;
  logic [DIST_W-1:0] row_dist;
  logic [LANE_W-1:0] row_lane;
  logic              take;
  logic              found_q, done_q;
  logic [DIST_W-1:0] best_q;
  logic [IDX_W-1:0]  idx_q;

  // Lanes in index order; strict compare keeps the earliest on ties.
  always_comb begin
    row_found = 1'b0;
    row_dist  = '0;
    row_lane  = '0;
    for (int l = 0; l < LANES; l++) begin
      if (in_i.vld[l] && (!row_found || in_i.distance[l] < row_dist)) begin
        row_found = 1'b1;
        row_dist  = in_i.distance[l];
        row_lane  = LANE_W'(l);
      end
    end
  end

  assign take = in_i.active && row_found && (!found_q || row_dist < best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= in_i.active && in_i.last;
      if (clear_i) begin
        found_q <= 1'b0;
      end else if (take) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_q <= row_dist;
      idx_q  <= {in_i.row, row_lane};
    end
  end

  assign res_o.done     = done_q;
  assign res_o.found    = found_q;
  assign res_o.distance = best_q;
  assign res_o.idx      = idx_q;

endmodule
`default_nettype wire

### rtl/hamming_nearest_descriptor_match.sv
// Brute-force Hamming nearest-descriptor matcher for 256-bit binary descriptors.
// Depends on hndm_pkg, hndm_lane, hndm_merge and the assertion macro header.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low.
//   func_i selects clear (empty the table), load (append the descriptor on
//   desc_word0_i..desc_word3_i) or query (match the descriptor). Code 3 is
//   ignored. Clear and load never raise busy; a load into
//   a full table is dropped.
//   A query compares against every stored reference. The table is split over
//   four lanes, each with its own bank, so one row of four references is
//   read per cycle. A query keeps busy high until its last row has passed the
//   bank read, popcount, sum and merge stages.
//   A query on an empty table never raises busy and gives nothing.
//   When the nearest reference (earliest index on ties) is strictly closer
//   than the threshold, result_valid_o pulses for one cycle, as busy
//   falls, with the query index, table index and distance. The receiver
//   cannot stall; a result is simply presented for that one cycle.
//   cfg_we_i writes the threshold; write it only while idle.
//   Reset empties the table, sets the threshold to 45 and drops any query.
//   No clearing pass is needed: only entries below the fill count are read.
`default_nettype none
`include "hamming_nearest_descriptor_match_assert.svh"
module hamming_nearest_descriptor_match (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   func_i,
  input  wire logic [hndm_pkg::QIDX_W-1:0]  query_index_i,
  input  wire logic [63:0]                  desc_word0_i,
  input  wire logic [63:0]                  desc_word1_i,
  input  wire logic [63:0]                  desc_word2_i,
  input  wire logic [63:0]                  desc_word3_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [hndm_pkg::THR_W-1:0]   cfg_wdata_i,
  output logic                              result_valid_o,
  output logic      [hndm_pkg::QIDX_W-1:0]  out_query_index_o,
  output logic      [hndm_pkg::OIDX_W-1:0]  best_ref_index_o,
  output logic      [8:0]                   best_distance_o
);
  import hndm_pkg::*;

  typedef struct packed {
    logic             active;
    logic             last;
    logic [ROW_W-1:0] row;
  } meta_t;

  state_e             state_q, state_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic [THR_W-1:0]   thr_q;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [DESC_W-1:0]  qdesc_q, qdesc_d;
  logic [QIDX_W-1:0]  qidx_q, qidx_d;
  logic [DESC_W-1:0]  in_desc;

  logic               accept;
  logic               load_we;
  logic [ROW_W-1:0]   load_row;
  logic [LANE_W-1:0]  load_lane;
  logic [ROW_W-1:0]   bank_addr;
  logic [COUNT_W-1:0] last_full;
  logic [ROW_W-1:0]   last_row;
  logic               scanning;
  logic [LANES-1:0]   ent_vld;

  meta_t              meta_q [LANE_LAT];
  meta_t              meta_iss;
  logic [LANES-1:0]   lane_vld;
  logic [LANES-1:0][DIST_W-1:0] lane_dist;
  lane_res_t          lane_res;
  merge_res_t         mres;
  logic               q_start;

  logic               res_vld_q, res_vld_d;
  logic [QIDX_W-1:0]  res_qidx_q;
  logic [OIDX_W-1:0]  res_idx_q;
  logic [8:0]         res_dist_q;
  logic [31:0]        idx_wide;

  assign in_desc = {desc_word3_i, desc_word2_i, desc_word1_i, desc_word0_i};
  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign q_start = accept && (func_i == FUNC_QUERY);

  // Next free slot: low bits pick the lane, the rest the row in that bank.
  assign load_lane = count_q[LANE_W-1:0];
  assign load_row  = count_q[ROW_W+LANE_W-1:LANE_W];
  assign load_we   = accept && (func_i == FUNC_LOAD) && (count_q < COUNT_W'(REF_DEPTH));

  // Last row holding a valid reference.
  assign last_full = (count_q - COUNT_W'(1)) >> LANE_W;
  assign last_row  = last_full[ROW_W-1:0];

  assign scanning  = (state_q == ST_SCAN);
  assign bank_addr = scanning ? row_q : load_row;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      ent_vld[l] = scanning &&
                   (((COUNT_W'(row_q) << LANE_W) | COUNT_W'(l)) < count_q);
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    row_d     = row_q;
    qdesc_d   = qdesc_q;
    qidx_d    = qidx_q;
    res_vld_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FUNC_CLEAR: begin
              count_d = '0;
            end
            FUNC_LOAD: begin
              if (load_we) begin
                count_d = count_q + COUNT_W'(1);
              end
            end
            FUNC_QUERY: begin
              qdesc_d = in_desc;
              qidx_d  = query_index_i;
              row_d   = '0;
              if (count_q != '0) begin
                state_d = ST_SCAN;
              end
            end
            default: begin
              // Unused code: drop it.
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (row_q == last_row) begin
          state_d = ST_DRAIN;
        end else begin
          row_d = row_q + ROW_W'(1);
        end
      end
      ST_DRAIN: begin
        // Hold until the merge stage has folded in the last row.
        if (mres.done) begin
          state_d   = ST_IDLE;
          res_vld_d = mres.found && (THR_W'(mres.distance) < thr_q);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      thr_q     <= THR_W'(DEF_THRESH);
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      res_vld_q <= res_vld_d;
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q   <= row_d;
    qdesc_q <= qdesc_d;
    qidx_q  <= qidx_d;
  end

  // Latch the result fields as the query finishes.
  assign idx_wide = 32'(mres.idx);

  always_ff @(posedge clk_i) begin
    if (res_vld_d) begin
      res_qidx_q <= qidx_q;
      res_idx_q  <= idx_wide[OIDX_W-1:0];
      res_dist_q <= 9'(mres.distance);
    end
  end

  // Row and last marker travel alongside the lane pipelines.
  assign meta_iss.active = scanning;
  assign meta_iss.last   = scanning && (row_q == last_row);
  assign meta_iss.row    = row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < LANE_LAT; s++) begin
        meta_q[s] <= '0;
      end
    end else begin
      meta_q[0] <= meta_iss;
      for (int s = 1; s < LANE_LAT; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    hndm_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .we_i    (load_we && (load_lane == LANE_W'(l))),
      .addr_i  (bank_addr),
      .wdata_i (in_desc),
      .rd_en_i (ent_vld[l]),
      .qdesc_i (qdesc_q),
      .vld_o   (lane_vld[l]),
      .dist_o  (lane_dist[l])
    );
  end

  assign lane_res.active   = meta_q[LANE_LAT-1].active;
  assign lane_res.last     = meta_q[LANE_LAT-1].last;
  assign lane_res.row      = meta_q[LANE_LAT-1].row;
  assign lane_res.vld      = lane_vld;
  assign lane_res.distance = lane_dist;

  hndm_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (q_start),
    .in_i    (lane_res),
    .res_o   (mres)
  );

  assign result_valid_o    = res_vld_q;
  assign out_query_index_o = res_qidx_q;
  assign best_ref_index_o  = res_idx_q;
  assign best_distance_o   = res_dist_q;

  `HNDM_ASSERT_IMPL(a_scan_nonempty, state_q == ST_SCAN, count_q != '0, "scan on empty table")
  `HNDM_ASSERT_IMPL(a_done_in_drain, mres.done, state_q == ST_DRAIN, "merge done outside drain")
  `HNDM_ASSERT_IMPL(a_result_idle, result_valid_o, !busy, "result while busy")
  `HNDM_ASSERT_NEXT(a_empty_query, q_start && (count_q == '0), !busy, "empty query stayed busy")

endmodule
`default_nettype wire

### tb/sv/hamming_nearest_descriptor_match_test.sv
// Self-checking testbench of the Hamming nearest-descriptor matcher.
// Needs hndm_pkg and hamming_nearest_descriptor_match; the expected matches
// come from a scoreboard class that keeps its own copy of the reference table.
`default_nettype none
module hamming_nearest_descriptor_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hndm_pkg::*;

  // Func code 3 has no member in the package enum; the block ignores it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  // A query result comes as busy falls; leave margin for that
  // and for a query that ends without a match.
  localparam int unsigned QUIET_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT  = 4000;

  localparam logic [DESC_W-1:0] ALL_ONES = {DESC_W{1'b1}};

  typedef struct {
    logic [QIDX_W-1:0] qidx;
    logic [OIDX_W-1:0] ref_idx;
    logic [8:0]        distance;
  } match_t;

  // Keep the reference table, the threshold and the matches still owed by
  // the block.
  class match_scoreboard;
    logic [DESC_W-1:0] refs[REF_DEPTH];
    int unsigned       fill;
    logic [THR_W-1:0]  threshold;
    match_t            pending_matches[$];
    int unsigned       errors;

    function new();
      fill      = 0;
      threshold = THR_W'(DEF_THRESH);
      errors    = 0;
    endfunction

    function void mismatch(string what, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // Apply one accepted transaction; a query may owe one match.
    function void note_item(logic [1:0] func, logic [QIDX_W-1:0] qidx,
                            logic [DESC_W-1:0] desc);
      int unsigned distance;
      int unsigned best;
      match_t      m;
      case (func)
        FUNC_CLEAR: fill = 0;
        FUNC_LOAD: begin
          // Drop the load once the table is full.
          if (fill < REF_DEPTH) begin
            refs[fill] = desc;
            fill++;
          end
        end
        FUNC_QUERY: begin
          best      = 0;
          m.ref_idx = '0;
          for (int unsigned j = 0; j < fill; j++) begin
            distance = $countones((desc ^ refs[j]) & DESC_MASK);
            // Strict compare keeps the earliest index on ties.
            if (j == 0 || distance < best) begin
              best      = distance;
              m.ref_idx = OIDX_W'(j);
            end
          end
          if (fill != 0 && best < threshold) begin
            m.qidx     = qidx;
            m.distance = 9'(best);
            pending_matches.insert(pending_matches.size(), m);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_match(logic [QIDX_W-1:0] qidx, logic [OIDX_W-1:0] ref_idx,
                              logic [8:0] distance);
      match_t want;
      if (pending_matches.size() == 0) begin
        errors++;
        $display("%0t: unexpected match, expected none, actual query %0d ref %0d dist %0d",
                 $time, qidx, ref_idx, distance);
        return;
      end
      want = pending_matches.pop_front();
      if (qidx !== want.qidx)         mismatch("query index", want.qidx, qidx);
      if (ref_idx !== want.ref_idx)   mismatch("reference index", want.ref_idx, ref_idx);
      if (distance !== want.distance) mismatch("distance", want.distance, distance);
    endfunction
  endclass

  logic                clk_i             = 1'b0;
  logic                rst_ni            = 1'b0;
  logic                start             = 1'b0;
  logic                busy;
  logic [1:0]          func_i            = FUNC_CLEAR;
  logic [QIDX_W-1:0]   query_index_i     = '0;
  logic [63:0]         desc_word0_i      = '0;
  logic [63:0]         desc_word1_i      = '0;
  logic [63:0]         desc_word2_i      = '0;
  logic [63:0]         desc_word3_i      = '0;
  logic                cfg_we_i          = 1'b0;
  logic [THR_W-1:0]    cfg_wdata_i       = '0;
  logic                result_valid_o;
  logic [QIDX_W-1:0]   out_query_index_o;
  logic [OIDX_W-1:0]   best_ref_index_o;
  logic [8:0]          best_distance_o;

  match_scoreboard     sb;
  int unsigned         idle_pct = 0;
  int unsigned         cycles   = 0;

  hamming_nearest_descriptor_match DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .func_i            (func_i),
    .query_index_i     (query_index_i),
    .desc_word0_i      (desc_word0_i),
    .desc_word1_i      (desc_word1_i),
    .desc_word2_i      (desc_word2_i),
    .desc_word3_i      (desc_word3_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .result_valid_o    (result_valid_o),
    .out_query_index_o (out_query_index_o),
    .best_ref_index_o  (best_ref_index_o),
    .best_distance_o   (best_distance_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Stop a hung run; a missing match mid-run also ends up here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // The strobe lasts one cycle and cannot be held off: check it at the edge
  // that ends it, against the oldest owed match.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      sb.check_match(out_query_index_o, best_ref_index_o, best_distance_o);
    end
  end

  function automatic logic [DESC_W-1:0] rand_desc();
    return {$urandom(), $urandom(), $urandom(), $urandom(),
            $urandom(), $urandom(), $urandom(), $urandom()};
  endfunction

  // Flip k random bit positions (repeats allowed) to move a query off a reference.
  function automatic logic [DESC_W-1:0] flip_bits(input logic [DESC_W-1:0] d,
                                                  input int unsigned k);
    logic [DESC_W-1:0] r;
    r = d;
    repeat (k) r[$urandom_range(0, DESC_W - 1)] ^= 1'b1;
    return r;
  endfunction

  // Drive one transaction and hold it until the block takes it. Drop start
  // for a random gap first when the sender is set to idle.
  task automatic send(input logic [1:0] func, input logic [QIDX_W-1:0] qidx,
                      input logic [DESC_W-1:0] desc);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start         <= 1'b1;
    func_i        <= func;
    query_index_i <= qidx;
    desc_word0_i  <= desc[63:0];
    desc_word1_i  <= desc[127:64];
    desc_word2_i  <= desc[191:128];
    desc_word3_i  <= desc[255:192];
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_item(func, qidx, desc);
  endtask

  // Wait until the block is idle with no match owed, then let a query that
  // ends without a match run out before anything else happens.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (busy || sb.pending_matches.size() != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_threshold(input int unsigned value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= THR_W'(value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.threshold = THR_W'(value);
  endtask

  // Blocks of clear, a few loads and a few queries. Most queries sit near a
  // stored reference so that matches are frequent; some are complements or
  // plain random descriptors, and unused func codes are mixed in as noise.
  task automatic run_random_phase(input int unsigned idle, input int unsigned target);
    int unsigned       sent;
    int unsigned       choice;
    logic [DESC_W-1:0] d;
    idle_pct = idle;
    sent     = 0;
    while (sent < target) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0:       set_threshold(0);
          1:       set_threshold(257);
          2:       set_threshold(DEF_THRESH);
          3, 4:    set_threshold($urandom_range(0, 257));
          default: set_threshold($urandom_range(8, 64));
        endcase
      end
      // Clear often, and always before the table grows slow to scan.
      if (sb.fill > 200 || $urandom_range(0, 2) == 0) begin
        send(FUNC_CLEAR, QIDX_W'($urandom_range(0, 65535)), rand_desc());
        sent++;
      end
      repeat ($urandom_range(0, 10)) begin
        // Reload an existing entry now and then to force distance ties.
        if (sb.fill != 0 && $urandom_range(0, 3) == 0) begin
          d = sb.refs[$urandom_range(0, sb.fill - 1)];
        end else begin
          d = rand_desc();
        end
        send(FUNC_LOAD, QIDX_W'($urandom_range(0, 65535)), d);
        sent++;
      end
      repeat ($urandom_range(1, 5)) begin
        choice = $urandom_range(0, 9);
        if (sb.fill == 0 || choice == 0) begin
          d = rand_desc();
        end else begin
          d = sb.refs[$urandom_range(0, sb.fill - 1)];
          if (choice == 1) begin
            d = ~d;
          end else if (choice < 4) begin
            d = flip_bits(d, $urandom_range(0, DESC_W));
          end else begin
            d = flip_bits(d, $urandom_range(0, 40));
          end
        end
        send(FUNC_QUERY, QIDX_W'($urandom_range(0, 65535)), d);
        sent++;
      end
      if ($urandom_range(0, 7) == 0) begin
        send(FUNC_UNUSED, QIDX_W'($urandom_range(0, 65535)), rand_desc());
      end
    end
  endtask

  initial begin : stimulus
    logic [DESC_W-1:0] pattern;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset threshold of 45.
    idle_pct = 13;
    send(FUNC_QUERY, '0, ALL_ONES);                  // empty table: no match
    send(FUNC_UNUSED, '1, ALL_ONES);                 // ignored
    send(FUNC_LOAD, '0, '0);
    send(FUNC_LOAD, '1, ALL_ONES);
    send(FUNC_LOAD, '0, '0);                         // duplicate of entry 0
    send(FUNC_QUERY, '1, '0);                        // tie at 0, earliest wins
    send(FUNC_QUERY, 16'h00ff, ALL_ONES);
    send(FUNC_QUERY, 16'h0100, ALL_ONES >> (DESC_W - 44));  // just under threshold
    send(FUNC_QUERY, 16'h0101, ALL_ONES >> (DESC_W - 45));  // at threshold: none
    send(FUNC_UNUSED, '0, '0);                       // ignored, table unchanged
    set_threshold(257);
    send(FUNC_QUERY, 16'h8000, ALL_ONES >> (DESC_W / 2));   // three-way tie at 128
    send(FUNC_CLEAR, '0, '0);
    send(FUNC_QUERY, 16'h7fff, '0);                  // empty after clear
    send(FUNC_LOAD, '0, ALL_ONES);
    send(FUNC_QUERY, 16'h5555, '0);                  // farthest possible: 256
    set_threshold(0);
    send(FUNC_QUERY, 16'haaaa, ALL_ONES);            // exact hit still rejected
    set_threshold(1);
    send(FUNC_QUERY, 16'h1234, ALL_ONES);
    set_threshold(DEF_THRESH);

    // Fill the table to the last entry, then push loads into the full table.
    idle_pct = 0;
    send(FUNC_CLEAR, '0, '0);
    for (int j = 0; j < REF_DEPTH; j++) send(FUNC_LOAD, QIDX_W'(j), rand_desc());
    pattern = rand_desc();
    repeat (3) send(FUNC_LOAD, '0, pattern);         // dropped
    send(FUNC_QUERY, 16'h0400, pattern);
    send(FUNC_QUERY, 16'hffff, sb.refs[REF_DEPTH - 1]);
    send(FUNC_QUERY, 16'h0001, flip_bits(sb.refs[0], 6));
    send(FUNC_CLEAR, '0, '0);

    run_random_phase(13, 180);
    run_random_phase(62, 180);
    run_random_phase(0, 180);

    // Drain: bounded wait for owed matches, then the tail latency.
    start <= 1'b0;
    @(posedge clk_i);
    for (int n = 0; n < DRAIN_LIMIT && (busy || sb.pending_matches.size() != 0); n++) begin
      @(posedge clk_i);
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
    if (sb.pending_matches.size() != 0) begin
      $display("%0t: %0d expected matches never arrived", $time,
               sb.pending_matches.size());
      sb.errors += sb.pending_matches.size();
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
`default_nettype wire
